// ===== rtl/hll_pkg.sv =====
// Shared types, codes and constants of the sketch unit.
package hll_pkg;

  localparam int unsigned ADDR_W_MAX = 18;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_MERGE    = 2'd1,
    ACT_ESTIMATE = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_VALUE = 2'd1,
    STS_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_SCAN_END,
    ST_ALPHA,
    ST_RAW_GO,
    ST_RAW,
    ST_LOG,
    ST_MUL_LO,
    ST_MUL_HI
  } back_state_e;

  typedef struct packed {
    action_e               act;
    logic [ADDR_W_MAX-1:0] addr;
    logic [5:0]            value;
    status_e               status;
  } item_t;

  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [79:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  // alpha in Q0.32 for the three smallest sketch sizes
  function automatic logic [31:0] alpha_small(input logic [4:0] p);
    logic [31:0] a;
    case (p)
      5'd4:    a = 32'd2890512990;
      5'd5:    a = 32'd2993592205;
      default: a = 32'd3045131813;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/hll_front.sv =====
// Front end: accepts commands, derives register address, rank and status.
module hll_front
  import hll_pkg::*;
(
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [63:0] hash_value_i,
  input  logic [15:0] reg_index_i,
  input  logic [5:0]  reg_value_i,
  input  logic [4:0]  p_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output item_t       q_item_o
);

  logic [63:0] rest;
  logic [63:0] at;
  logic [6:0]  lz;
  logic [6:0]  maxrank;
  logic [6:0]  rank;
  logic [18:0] idx_hi;

  assign busy     = q_full_i;
  assign q_push_o = start && !q_full_i;

  always_comb begin
    rest    = hash_value_i << p_i;
    at      = hash_value_i >> (7'd64 - 7'(p_i));
    maxrank = 7'd65 - 7'(p_i);
    lz      = 7'd0;
    // highest set position wins last, so scan upward and keep the highest 1
    for (int i = 0; i < 64; i++) begin
      if (rest[i]) lz = 7'(63 - i);
    end
    rank   = (rest == 64'd0) ? maxrank : lz + 7'd1;
    idx_hi = 19'(reg_index_i) >> p_i;

    q_item_o.act    = action_e'(action_i);
    q_item_o.addr   = '0;
    q_item_o.value  = '0;
    q_item_o.status = STS_OK;
    case (action_e'(action_i))
      ACT_ADD: begin
        q_item_o.addr  = at[ADDR_W_MAX-1:0];
        q_item_o.value = rank[5:0];
      end
      ACT_MERGE: begin
        q_item_o.addr  = ADDR_W_MAX'(reg_index_i);
        q_item_o.value = reg_value_i;
        if (idx_hi != 19'd0) q_item_o.status = STS_BAD_INDEX;
        else if (7'(reg_value_i) > maxrank) q_item_o.status = STS_BAD_VALUE;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/hll_queue.sv =====
// Two-entry command queue between front and back.
module hll_queue
  import hll_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== rtl/hll_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit saturating quotient.
module hll_div
  import hll_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [127:0] n_q;
  logic [80:0]  r_q;
  logic [79:0]  d_q;
  logic [63:0]  q_q;
  logic         ovf_q;
  logic [6:0]   cnt_q;
  logic         run_q, done_q;
  logic [80:0]  rs;
  logic         ge;

  assign rs = {r_q[79:0], n_q[127]};
  assign ge = rs >= 81'(d_q);

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = ovf_q ? '1 : q_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q   <= req_i.num;
      d_q   <= req_i.den;
      r_q   <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (run_q) begin
      n_q   <= {n_q[126:0], 1'b0};
      r_q   <= ge ? rs - 81'(d_q) : rs;
      q_q   <= {q_q[62:0], ge};
      ovf_q <= ovf_q | q_q[63];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && cnt_q == 7'd127;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) run_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/hll_back.sv =====
// Back end: rank memory, clearing sweep and estimate sequencer.
module hll_back
  import hll_pkg::*;
#(
  parameter int unsigned AW = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [4:0]  p_i,
  input  logic        cfg_clr_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [63:0] cardinality_o,
  output logic        estimate_valid_o
);

  logic [5:0]  mem [2**AW];
  logic [5:0]  rdata_q;
  logic [AW-1:0] ra, wa;
  logic [5:0]  wd;
  logic        we;

  back_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic        clr_item_q, clr_item_d;
  item_t       cur_q, cur_d;
  logic        scan_v_q;
  logic [79:0] sum_q, sum_d;
  logic [AW:0] zero_q, zero_d;
  logic [31:0] alpha_q, alpha_d;
  logic [4:0]  e_q, e_d;
  logic [31:0] x_q, x_d, frac_q, frac_d;
  logic [4:0]  it_q, it_d;
  logic [63:0] prod_q, prod_d;
  logic        rv_d;
  logic [1:0]  st_d;
  logic [63:0] card_d;
  logic        ev_d;

  logic [AW:0]  m_full;
  logic         last;
  logic [63:0]  sq;
  logic [32:0]  y;
  logic [37:0]  lval;
  logic [37:0]  tval;
  logic [63:0]  d_val;
  logic [6:0]   sh;

  assign m_full = (AW+1)'(1) << p_i;
  assign last   = cnt_q == AW'(m_full - (AW+1)'(1));
  assign sq     = 64'(x_q) * 64'(x_q);
  assign y      = sq[63:31];
  assign lval   = 38'({p_i, 32'd0}) - 38'({e_q, frac_q});
  assign tval   = 38'(lval[37:32] * LN2_Q32) + 38'(prod_q[63:32]);
  assign d_val  = (64'd10000 << p_i) + 64'd10790;
  assign sh     = 7'(2 * p_i) + 7'd37;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rdata_q <= mem[ra];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    clr_item_d = clr_item_q;
    cur_d      = cur_q;
    sum_d      = sum_q;
    zero_d     = zero_q;
    alpha_d    = alpha_q;
    e_d        = e_q;
    x_d        = x_q;
    frac_d     = frac_q;
    it_d       = it_q;
    prod_d     = prod_q;
    rv_d       = 1'b0;
    st_d       = STS_OK;
    card_d     = '0;
    ev_d       = 1'b0;
    q_pop_o    = 1'b0;
    ra         = q_item_i.addr[AW-1:0];
    wa         = cnt_q;
    wd         = '0;
    we         = 1'b0;
    div_req_o  = '0;

    // accumulate scan data one read behind the address
    if (scan_v_q) begin
      sum_d  = sum_q + (80'd1 << (6'd61 - rdata_q));
      zero_d = zero_q + (AW+1)'(rdata_q == 6'd0);
    end

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_q + AW'(1);
        if (last) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
          rv_d    = clr_item_q;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          unique case (q_item_i.act) inside
            ACT_ADD, ACT_MERGE: state_d = ST_WRITE;
            ACT_ESTIMATE: begin
              cnt_d   = '0;
              sum_d   = '0;
              zero_d  = '0;
              state_d = ST_SCAN;
            end
            default: begin
              cnt_d      = '0;
              clr_item_d = 1'b1;
              state_d    = ST_CLEAR;
            end
          endcase
        end
      end
      ST_WRITE: begin
        wa = cur_q.addr[AW-1:0];
        wd = cur_q.value;
        we = cur_q.status == STS_OK && cur_q.value > rdata_q;
        rv_d    = 1'b1;
        st_d    = cur_q.status;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        ra    = cnt_q;
        cnt_d = cnt_q + AW'(1);
        if (last) state_d = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        if (p_i > 5'd6) begin
          div_req_o.start = 1'b1;
          div_req_o.num   = 128'((64'd7213 << (7'd32 + 7'(p_i))) + (d_val >> 1));
          div_req_o.den   = 80'(d_val);
          state_d         = ST_ALPHA;
        end else begin
          alpha_d = alpha_small(p_i);
          state_d = ST_RAW_GO;
        end
      end
      ST_ALPHA: begin
        if (div_rsp_i.done) begin
          alpha_d = div_rsp_i.quo[31:0];
          state_d = ST_RAW_GO;
        end
      end
      ST_RAW_GO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = 128'(alpha_q) << sh;
        div_req_o.den   = sum_q;
        state_d         = ST_RAW;
      end
      ST_RAW: begin
        if (div_rsp_i.done) begin
          e_d = '0;
          for (int i = 0; i <= AW; i++) begin
            if (zero_q[i]) e_d = 5'(i);
          end
          x_d    = 32'(zero_q) << (5'd31 - e_d);
          frac_d = '0;
          it_d   = '0;
          if (div_rsp_i.quo <= (64'd640 << p_i) && zero_q != '0) begin
            state_d = ST_LOG;
          end else begin
            rv_d    = 1'b1;
            ev_d    = 1'b1;
            card_d  = div_rsp_i.quo;
            state_d = ST_IDLE;
          end
        end
      end
      ST_LOG: begin
        frac_d = {frac_q[30:0], y[32]};
        x_d    = y[32] ? y[32:1] : y[31:0];
        it_d   = it_q + 5'd1;
        if (it_q == 5'd31) state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        prod_d  = 64'(lval[31:0]) * 64'(LN2_Q32);
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        rv_d    = 1'b1;
        ev_d    = 1'b1;
        card_d  = (64'(tval) << p_i) >> 24;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // a register write starts a fresh sketch
    if (cfg_clr_i) begin
      state_d    = ST_CLEAR;
      cnt_d      = '0;
      clr_item_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      cnt_q          <= '0;
      clr_item_q     <= 1'b0;
      scan_v_q       <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      clr_item_q     <= clr_item_d;
      scan_v_q       <= state_q == ST_SCAN;
      result_valid_o <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q            <= cur_d;
    sum_q            <= sum_d;
    zero_q           <= zero_d;
    alpha_q          <= alpha_d;
    e_q              <= e_d;
    x_q              <= x_d;
    frac_q           <= frac_d;
    it_q             <= it_d;
    prod_q           <= prod_d;
    status_o         <= st_d;
    cardinality_o    <= card_d;
    estimate_valid_o <= ev_d;
  end

endmodule

// ===== rtl/hyperloglog_sketch_unit.sv =====
// Top level of the cardinality sketch unit.
// Commands enter on start while busy is low and go through a two-entry queue
// to the back end, which owns a rank memory (one read port, one write port) of
// 2^MAX_PRECISION six-bit entries. Each command that no precision write cuts off
// gives exactly one result, shown for one cycle on result_valid_o; the receiver
// must take it. An add or merge reads the memory as it leaves the queue, then
// compares and writes. A clear sweeps 2^p entries at one a cycle, and the same
// sweep runs after reset and after every precision write; commands queue up
// behind it. An estimate scans 2^p entries, then runs the bit-serial divider
// once for p up to 6 or twice for larger p, followed by a log evaluation when
// linear counting applies.
module hyperloglog_sketch_unit
  import hll_pkg::*;
#(
  parameter int unsigned MAX_PRECISION = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [63:0] hash_value_i,
  input  logic [15:0] reg_index_i,
  input  logic [5:0]  reg_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [63:0] cardinality_o,
  output logic        estimate_valid_o
);

  logic [4:0] precision_q;
  logic [4:0] p_eff;
  logic       cfg_wr;
  logic       q_push, q_full, q_pop, q_valid;
  item_t      f_item, b_item;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign p_eff = (precision_q < 5'd4) ? 5'd4 :
                 (precision_q > 5'(MAX_PRECISION)) ? 5'(MAX_PRECISION) : precision_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) precision_q <= 5'd14;
    else if (cfg_wr) precision_q <= cfg_data_i;
  end

  hll_front u_front (
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .hash_value_i (hash_value_i),
    .reg_index_i  (reg_index_i),
    .reg_value_i  (reg_value_i),
    .p_i          (p_eff),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (f_item)
  );

  hll_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (b_item)
  );

  hll_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  hll_back #(
    .AW (MAX_PRECISION)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .p_i              (p_eff),
    .cfg_clr_i        (cfg_wr),
    .q_valid_i        (q_valid),
    .q_item_i         (b_item),
    .q_pop_o          (q_pop),
    .div_req_o        (div_req),
    .div_rsp_i        (div_rsp),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .cardinality_o    (cardinality_o),
    .estimate_valid_o (estimate_valid_o)
  );

endmodule

// ===== rtl/hll_checker.sv =====
// Port-level checks of the sketch unit, bound to the top level.
module hll_checker
  import hll_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic [1:0]  status_o,
  input logic [63:0] cardinality_o,
  input logic        estimate_valid_o
);

  a_est_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    estimate_valid_o |-> result_valid_o)
    else $error("estimate flag without result strobe");

  a_zero_card: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !estimate_valid_o |-> cardinality_o == 64'd0)
    else $error("nonzero cardinality on a non-estimate result");

  a_est_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && estimate_valid_o |-> status_o == STS_OK)
    else $error("estimate result with error status");

endmodule

bind hyperloglog_sketch_unit hll_checker u_hll_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .result_valid_o   (result_valid_o),
  .status_o         (status_o),
  .cardinality_o    (cardinality_o),
  .estimate_valid_o (estimate_valid_o)
);
